// ===== rtl/tlsd_pkg.sv =====
`default_nettype none

package tlsd_pkg;

    localparam int unsigned CountW = 16;

    // configuration register indexes
    localparam logic CFG_TEST_MODE = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [CountW-1:0] THRESHOLD_RESET  = 16'd300;
    localparam logic [CountW-1:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [CountW-1:0] TEST_LATCH_COUNT = 16'd3;

    // high nibble tags in normal mode
    localparam logic [3:0] TAG_X_COARSE = 4'h2;
    localparam logic [3:0] TAG_X_FINE   = 4'h3;
    localparam logic [3:0] TAG_Y_COARSE = 4'h4;
    localparam logic [3:0] TAG_Y_FINE   = 4'h5;
    localparam logic [3:0] TAG_Z        = 4'h6;

    // normal level window
    localparam logic [7:0] X_FINE_LO     = 8'h30;
    localparam logic [7:0] X_FINE_HI_A   = 8'h3E;
    localparam logic [7:0] X_FINE_HI_B   = 8'h3F;
    localparam logic [7:0] X_COARSE_MAX  = 8'h2A;
    localparam logic [7:0] Y_FINE_LO     = 8'h5D;
    localparam logic [7:0] Y_FINE_HI_A   = 8'h5E;
    localparam logic [7:0] Y_FINE_HI_B   = 8'h5F;
    localparam logic [7:0] Y_COARSE_MIN  = 8'h49;

    // test mode exact codes
    localparam logic [7:0] TST_X_COARSE = 8'h32;
    localparam logic [7:0] TST_X_FINE   = 8'h33;
    localparam logic [7:0] TST_Y_COARSE = 8'h34;
    localparam logic [7:0] TST_Y_FINE   = 8'h35;
    localparam logic [7:0] TST_Z_A      = 8'h36;
    localparam logic [7:0] TST_Z_B      = 8'h37;

    typedef struct packed {
        logic advance;
        logic test_mode;
    } t_step;

endpackage

`default_nettype wire

// ===== rtl/tlsd_slots.sv =====
`default_nettype none

module tlsd_slots
    import tlsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step      i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_ok
);

    logic [7:0] r_x_coarse, r_x_fine, r_y_coarse, r_y_fine, r_z_value;
    logic [7:0] n_x_coarse, n_x_fine, n_y_coarse, n_y_fine, n_z_value;
    logic       r_fine_taken, n_fine_taken;
    logic       x_ok, y_ok, norm_ok, test_ok;

    always_comb begin
        n_x_coarse   = r_x_coarse;
        n_x_fine     = r_x_fine;
        n_y_coarse   = r_y_coarse;
        n_y_fine     = r_y_fine;
        n_z_value    = r_z_value;
        n_fine_taken = r_fine_taken;
        if (i_step.test_mode) begin
            case (i_byte) inside
                TST_X_COARSE: begin
                    n_x_coarse   = i_byte;
                    n_fine_taken = 1'b0;
                end
                TST_X_FINE: begin
                    n_x_fine     = i_byte;
                    n_fine_taken = 1'b1;
                end
                TST_Y_COARSE: n_y_coarse = i_byte;
                TST_Y_FINE:   n_y_fine   = i_byte;
                TST_Z_A, TST_Z_B: n_z_value = i_byte;
                default: ;
            endcase
        end else begin
            case (i_byte[7:4])
                TAG_X_COARSE: begin
                    n_x_coarse   = i_byte;
                    n_fine_taken = 1'b0;
                end
                TAG_X_FINE: begin
                    if (!r_fine_taken) begin
                        n_x_fine     = i_byte;
                        n_fine_taken = 1'b1;
                    end
                end
                TAG_Y_COARSE: n_y_coarse = i_byte;
                TAG_Y_FINE:   n_y_fine   = i_byte;
                TAG_Z:        n_z_value  = i_byte;
                default: ;
            endcase
        end
    end

    // window is tested on the slots after this item lands
    always_comb begin
        x_ok = (n_x_fine == X_FINE_HI_A) || (n_x_fine == X_FINE_HI_B) ||
               ((n_x_fine == X_FINE_LO) && (n_x_coarse <= X_COARSE_MAX));
        y_ok = (n_y_fine == Y_FINE_HI_A) || (n_y_fine == Y_FINE_HI_B) ||
               ((n_y_fine == Y_FINE_LO) && (n_y_coarse >= Y_COARSE_MIN));
        norm_ok = x_ok && y_ok;
        test_ok = (n_x_fine == TST_X_FINE) && (n_x_coarse == TST_X_COARSE) &&
                  (n_y_fine == TST_Y_FINE) && (n_y_coarse == TST_Y_COARSE) &&
                  (n_z_value == TST_Z_A);
        o_ok = i_step.test_mode ? test_ok : norm_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_coarse   <= '0;
            r_x_fine     <= '0;
            r_y_coarse   <= '0;
            r_y_fine     <= '0;
            r_z_value    <= '0;
            r_fine_taken <= 1'b0;
        end else if (i_step.advance) begin
            r_x_coarse   <= n_x_coarse;
            r_x_fine     <= n_x_fine;
            r_y_coarse   <= n_y_coarse;
            r_y_fine     <= n_y_fine;
            r_z_value    <= n_z_value;
            r_fine_taken <= n_fine_taken;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tlsd_count.sv =====
`default_nettype none

module tlsd_count
    import tlsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_step             i_step,
    input  wire logic              i_ok,
    input  wire logic [CountW-1:0] i_threshold,
    output logic [CountW-1:0]      o_count,
    output logic                   o_latch
);

    logic [CountW-1:0] r_run_count, n_run_count;
    logic              r_led_latch, n_led_latch;

    always_comb begin
        n_run_count = r_run_count;
        n_led_latch = r_led_latch;
        if (i_ok) begin
            if (r_run_count != COUNT_MAX) begin
                n_run_count = r_run_count + 1'b1;
            end
            if (i_step.test_mode) begin
                if (n_run_count == TEST_LATCH_COUNT) begin
                    n_led_latch = 1'b1;
                end
            end else if (n_run_count >= i_threshold) begin
                n_led_latch = 1'b1;
            end
        end else begin
            n_run_count = '0;
            n_led_latch = 1'b0;
        end
    end

    assign o_count = n_run_count;
    assign o_latch = n_led_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= '0;
            r_led_latch <= 1'b0;
        end else if (i_step.advance) begin
            r_run_count <= n_run_count;
            r_led_latch <= n_led_latch;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tilt_level_stability_detector.sv =====
// Tilt level stability detector.
// Input channel: i_valid / o_ready with i_rx_byte, one received byte per item.
// Output channel: o_valid / i_ready with o_level_ok, o_stable_flag and
// o_stable_count, one result item per input item, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 test_mode, 1 stable_threshold) at the clock edge; write only when idle.
// Pipeline: an accepted byte waits in the input register, then slot update,
// window test and counter update run in one pass into the result register.
// Throughput: one item per cycle while the output is not stalled; the slot
// and counter registers are updated as each item moves from the input
// register to the result register.
// Stall: when i_ready is low the result register holds, the input register
// keeps one more item, and o_ready drops only when both are full.
// Reset (synchronous, active low): slots, count and flag clear, threshold
// returns to 300, test mode off, both channels empty.
`default_nettype none

module tilt_level_stability_detector
    import tlsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_level_ok,
    output logic                   o_stable_flag,
    output logic [CountW-1:0]      o_stable_count,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CountW-1:0] i_cfg_data
);

    logic              r_test_mode;
    logic [CountW-1:0] r_threshold;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    logic              r_out_ok;
    logic              r_out_flag;
    logic [CountW-1:0] r_out_count;
    logic              out_free;
    logic              advance;
    logic              win_ok;
    logic [CountW-1:0] cnt_next;
    logic              latch_next;
    t_step             step;

    assign out_free       = !r_out_valid || i_ready;
    assign advance        = r_in_valid && out_free;
    assign o_ready        = !r_in_valid || out_free;
    assign step.advance   = advance;
    assign step.test_mode = r_test_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_mode <= 1'b0;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEST_MODE: r_test_mode <= i_cfg_data[0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    tlsd_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_ok    (win_ok)
    );

    tlsd_count u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ok        (win_ok),
        .i_threshold (r_threshold),
        .o_count     (cnt_next),
        .o_latch     (latch_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ok    <= win_ok;
            r_out_flag  <= latch_next;
            r_out_count <= cnt_next;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_level_ok     = r_out_ok;
    assign o_stable_flag  = r_out_flag;
    assign o_stable_count = r_out_count;

endmodule

`default_nettype wire
